### rtl/twpi_pkg.sv
package twpi_pkg;

    localparam int MODE_W  = 3;
    localparam int TRAV_W  = 24;
    localparam int OFS_W   = 26;
    localparam int BOFS_W  = 27;
    localparam int POSE_W  = 32;
    localparam int HDEG_W  = 25;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 27;

    // datapath widths
    localparam int OPW  = 34;          // multiplier / CORDIC operand
    localparam int PRW  = 2 * OPW;     // product and accumulator
    localparam int DVW  = 64;          // divider numerator / quotient

    localparam logic [MODE_W-1:0] MODE_UPDATE    = 3'd0;
    localparam logic [MODE_W-1:0] MODE_RST_X     = 3'd1;
    localparam logic [MODE_W-1:0] MODE_RST_Y     = 3'd2;
    localparam logic [MODE_W-1:0] MODE_RST_HEAD  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_RST_ALL   = 3'd4;

    localparam logic [CFG_IDX_W-1:0] REG_RIGHT_OFS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LEFT_OFS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BACK_OFS  = 2'd2;

    localparam logic [OFS_W-1:0]  RIGHT_OFS_RST = 26'd393216;
    localparam logic [OFS_W-1:0]  LEFT_OFS_RST  = 26'd393216;
    localparam logic [BOFS_W-1:0] BACK_OFS_RST  = 27'd262144;

    // round(2^32 / 2pi) and CORDIC start value 1/K in Q30
    localparam logic signed [OPW-1:0] INV_TWO_PI = 34'sd683565276;
    localparam logic signed [OPW-1:0] CORDIC_X0  = 34'sd652032875;
    localparam logic signed [OPW-1:0] ONE_Q30    = 34'sd1073741824;

    typedef logic signed [OPW-1:0] op_t;
    typedef logic signed [PRW-1:0] prod_t;

    typedef struct packed {
        logic                     clip;
        logic signed [POSE_W-1:0] val;
    } sat_t;

    function automatic logic [31:0] atan_turn(input logic [4:0] i);
        logic [31:0] r;
        case (i)
            5'd0:  r = 32'h20000000;
            5'd1:  r = 32'h12E4051D;
            5'd2:  r = 32'h09FB385B;
            5'd3:  r = 32'h051111D4;
            5'd4:  r = 32'h028B0D43;
            5'd5:  r = 32'h0145D7E1;
            5'd6:  r = 32'h00A2F61E;
            5'd7:  r = 32'h00517C55;
            5'd8:  r = 32'h0028BE53;
            5'd9:  r = 32'h00145F2E;
            5'd10: r = 32'h000A2F98;
            5'd11: r = 32'h000517CC;
            5'd12: r = 32'h00028BE6;
            5'd13: r = 32'h000145F3;
            5'd14: r = 32'h0000A2F9;
            5'd15: r = 32'h0000517C;
            5'd16: r = 32'h000028BE;
            5'd17: r = 32'h0000145F;
            5'd18: r = 32'h00000A2F;
            5'd19: r = 32'h00000517;
            5'd20: r = 32'h0000028B;
            5'd21: r = 32'h00000145;
            5'd22: r = 32'h000000A2;
            5'd23: r = 32'h00000051;
            5'd24: r = 32'h00000028;
            5'd25: r = 32'h00000014;
            5'd26: r = 32'h0000000A;
            5'd27: r = 32'h00000005;
            5'd28: r = 32'h00000002;
            5'd29: r = 32'h00000001;
            default: r = 32'h00000000;
        endcase
        return r;
    endfunction

    function automatic sat_t sat_add(input logic signed [POSE_W-1:0] a,
                                     input logic signed [PRW-31:0] d);
        logic signed [PRW-29:0] s;
        sat_t r;
        s = (PRW-28)'(a) + (PRW-28)'(d);
        r.clip = 1'b0;
        r.val  = s[POSE_W-1:0];
        if (s > (PRW-28)'(signed'(32'sh7FFFFFFF))) begin
            r.clip = 1'b1;
            r.val  = 32'sh7FFFFFFF;
        end else if (s < (PRW-28)'(signed'(32'sh80000000))) begin
            r.clip = 1'b1;
            r.val  = 32'sh80000000;
        end
        return r;
    endfunction

endpackage

### rtl/three_wheel_pose_integrator.sv
// Three-wheel dead-reckoning pose integrator. Each accepted update computes the heading
// change with a 64-step restoring divider, converts it to a binary angle, runs a CORDIC
// for the half angle, divides again for the chord factor when the angle is not tiny,
// then runs the CORDIC for the mid-step heading and rotates the local move into X/Y
// with saturation. All arithmetic goes through one divider, one CORDIC stage and one
// 34x34 multiplier under a sequencer. The first division is skipped when the wheel offsets
// sum to zero, and the half-angle CORDIC and chord division when the angle is zero; reset
// and unknown modes go straight to the output state. The input is not ready while an item
// is in flight; the result sits in an output register until taken.
module three_wheel_pose_integrator
    import twpi_pkg::*;
#(
    parameter int FRAC_BITS       = 16,
    parameter int TRIG_ITERATIONS = 24
) (
    input  logic                       aclk,
    input  logic                       aresetn,

    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [CFG_IDX_W-1:0]       cfg_index,
    input  logic [CFG_DAT_W-1:0]       cfg_data,

    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [MODE_W-1:0]          s_mode,
    input  logic signed [TRAV_W-1:0]   s_left_travel,
    input  logic signed [TRAV_W-1:0]   s_right_travel,
    input  logic signed [TRAV_W-1:0]   s_back_travel,

    output logic                       m_valid,
    input  logic                       m_ready,
    output logic signed [POSE_W-1:0]   m_pose_x,
    output logic signed [POSE_W-1:0]   m_pose_y,
    output logic [HDEG_W-1:0]          m_heading_degrees,
    output logic                       m_arc_used,
    output logic                       m_saturated
);

    localparam int HSH = 32 - FRAC_BITS;

    localparam logic [4:0] S_IDLE = 5'd0,  S_DIV = 5'd1,  S_DM0 = 5'd2,  S_DM1 = 5'd3,
                           S_DM2  = 5'd4,  S_DMCHK = 5'd5, S_CST = 5'd6, S_COR = 5'd7,
                           S_L0   = 5'd8,  S_L1 = 5'd9,   S_L2 = 5'd10, S_L3 = 5'd11,
                           S_L4   = 5'd12, S_L5 = 5'd13,  S_L6 = 5'd14, S_G0 = 5'd15,
                           S_G1   = 5'd16, S_G2 = 5'd17,  S_G3 = 5'd18, S_G4 = 5'd19,
                           S_G5   = 5'd20, S_G6 = 5'd21,  S_OUT = 5'd22;

    logic [4:0] state_reg, state_next;
    logic [OFS_W-1:0] ro_reg, ro_next, lo_reg, lo_next;
    logic signed [BOFS_W-1:0] bo_reg, bo_next;
    logic signed [POSE_W-1:0] accx_reg, accx_next, accy_reg, accy_next;
    logic [31:0] head_reg, head_next;
    logic signed [TRAV_W-1:0] rt_reg, rt_next, bt_reg, bt_next;
    logic neg_reg, neg_next, big_reg, big_next, arc_reg, arc_next, clip_reg, clip_next;
    logic [31:0] d32_reg, d32_next, h32_reg, h32_next;
    logic [DVW-1:0] qm_reg, qm_next, quo_reg, quo_next, den_reg, den_next;
    logic [DVW:0] rem_reg, rem_next;
    logic [6:0] cnt_reg, cnt_next;
    logic div_sel_reg, div_sel_next, cor_sel_reg, cor_sel_next, flip_reg, flip_next;
    op_t cx_reg, cx_next, cy_reg, cy_next, cz_reg, cz_next;
    op_t s2_reg, s2_next, c_reg, c_next, lx_reg, lx_next, ly_reg, ly_next;
    op_t sn_reg, sn_next, cs_reg, cs_next;
    prod_t prod_reg, acc_reg, acc_next;
    logic m_valid_reg, m_valid_next;
    logic signed [POSE_W-1:0] ox_reg, ox_next, oy_reg, oy_next;
    logic [HDEG_W-1:0] oh_reg, oh_next;
    logic oarc_reg, oarc_next, osat_reg, osat_next;

    op_t mul_a, mul_b;
    prod_t prod;

    // shared multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_DM0: begin mul_a = op_t'({2'b0, qm_reg[31:0]});  mul_b = INV_TWO_PI; end
            S_DM1: begin mul_a = op_t'({2'b0, qm_reg[63:32]}); mul_b = INV_TWO_PI; end
            S_L0:  begin mul_a = c_reg;  mul_b = op_t'(bt_reg); end
            S_L1:  begin mul_a = s2_reg; mul_b = op_t'(bo_reg); end
            S_L3:  begin mul_a = c_reg;  mul_b = op_t'(rt_reg); end
            S_L4:  begin mul_a = s2_reg; mul_b = op_t'({8'b0, ro_reg}); end
            S_G0:  begin mul_a = lx_reg; mul_b = cs_reg; end
            S_G1:  begin mul_a = ly_reg; mul_b = sn_reg; end
            S_G3:  begin mul_a = lx_reg; mul_b = sn_reg; end
            S_G4:  begin mul_a = ly_reg; mul_b = cs_reg; end
            default: begin mul_a = '0; mul_b = '0; end
        endcase
    end

    assign prod = mul_a * mul_b;

    // divider step
    logic [DVW:0] div_sh;
    logic         div_ge;
    assign div_sh = {rem_reg[DVW-1:0], quo_reg[DVW-1]};
    assign div_ge = div_sh >= {1'b0, den_reg};

    // CORDIC step
    op_t cor_xs, cor_ys, cor_at, cor_sf, cor_cf, s2_new, s2_abs;
    assign cor_xs = cx_reg >>> cnt_reg[4:0];
    assign cor_ys = cy_reg >>> cnt_reg[4:0];
    assign cor_at = op_t'({2'b0, atan_turn(cnt_reg[4:0])});
    assign cor_sf = flip_reg ? -cy_reg : cy_reg;
    assign cor_cf = flip_reg ? -cx_reg : cx_reg;
    assign s2_new = cor_sf <<< 1;
    assign s2_abs = s2_new[OPW-1] ? -s2_new : s2_new;

    logic [31:0] cor_ang, cor_tmp;
    assign cor_ang = cor_sel_reg ? (head_reg + h32_reg) : h32_reg;
    assign cor_tmp = cor_ang + 32'h40000000;

    // input-side arithmetic
    logic signed [TRAV_W:0] diff;
    logic [TRAV_W:0] diff_abs;
    logic [OFS_W:0] ofs_sum;
    assign diff     = (TRAV_W+1)'(s_left_travel) - (TRAV_W+1)'(s_right_travel);
    assign diff_abs = diff[TRAV_W] ? (TRAV_W+1)'(-diff) : (TRAV_W+1)'(diff);
    assign ofs_sum  = (OFS_W+1)'(ro_reg) + (OFS_W+1)'(lo_reg);

    logic [55:0] dm;
    assign dm = acc_reg[55:0];

    sat_t sat_r;
    always_comb begin
        if (state_reg == S_G3) begin
            sat_r = sat_add(accx_reg, acc_reg[PRW-1:30]);
        end else begin
            sat_r = sat_add(accy_reg, acc_reg[PRW-1:30]);
        end
    end

    logic [56:0] hprod;
    assign hprod = 57'(head_reg) * 57'd360;

    assign s_ready   = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;

    always_comb begin
        state_next = state_reg;
        ro_next = ro_reg; lo_next = lo_reg; bo_next = bo_reg;
        accx_next = accx_reg; accy_next = accy_reg; head_next = head_reg;
        rt_next = rt_reg; bt_next = bt_reg;
        neg_next = neg_reg; big_next = big_reg; arc_next = arc_reg; clip_next = clip_reg;
        d32_next = d32_reg; h32_next = h32_reg;
        qm_next = qm_reg; quo_next = quo_reg; den_next = den_reg; rem_next = rem_reg;
        cnt_next = cnt_reg; div_sel_next = div_sel_reg; cor_sel_next = cor_sel_reg;
        flip_next = flip_reg;
        cx_next = cx_reg; cy_next = cy_reg; cz_next = cz_reg;
        s2_next = s2_reg; c_next = c_reg; lx_next = lx_reg; ly_next = ly_reg;
        sn_next = sn_reg; cs_next = cs_reg;
        acc_next = acc_reg;
        m_valid_next = m_valid_reg & ~m_ready;
        ox_next = ox_reg; oy_next = oy_reg; oh_next = oh_reg;
        oarc_next = oarc_reg; osat_next = osat_reg;

        if (cfg_valid) begin
            case (cfg_index)
                REG_RIGHT_OFS: ro_next = cfg_data[OFS_W-1:0];
                REG_LEFT_OFS:  lo_next = cfg_data[OFS_W-1:0];
                REG_BACK_OFS:  bo_next = cfg_data[BOFS_W-1:0];
                default: ;
            endcase
        end

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    arc_next  = 1'b0;
                    clip_next = 1'b0;
                    rt_next   = s_right_travel;
                    bt_next   = s_back_travel;
                    neg_next  = diff[TRAV_W];
                    state_next = S_OUT;
                    case (s_mode)
                        MODE_UPDATE: begin
                            quo_next = {7'b0, diff_abs, 32'b0};
                            den_next = DVW'(ofs_sum);
                            rem_next = '0;
                            cnt_next = '0;
                            div_sel_next = 1'b0;
                            if (ofs_sum == '0) begin
                                qm_next = '0;
                                state_next = S_DM0;
                            end else begin
                                state_next = S_DIV;
                            end
                        end
                        MODE_RST_X:    accx_next = '0;
                        MODE_RST_Y:    accy_next = '0;
                        MODE_RST_HEAD: head_next = '0;
                        MODE_RST_ALL: begin
                            accx_next = '0;
                            accy_next = '0;
                            head_next = '0;
                        end
                        default: ;
                    endcase
                end
            end
            S_DIV: begin
                if (cnt_reg == 7'(DVW)) begin
                    if (!div_sel_reg) begin
                        qm_next = quo_reg;
                        state_next = S_DM0;
                    end else begin
                        c_next = (s2_reg[OPW-1] != neg_reg) ? -op_t'({1'b0, quo_reg[32:0]})
                                                            :  op_t'({1'b0, quo_reg[32:0]});
                        state_next = S_L0;
                    end
                end else begin
                    rem_next = div_ge ? (div_sh - {1'b0, den_reg}) : div_sh;
                    quo_next = {quo_reg[DVW-2:0], div_ge};
                    cnt_next = cnt_reg + 7'd1;
                end
            end
            S_DM0: state_next = S_DM1;
            S_DM1: begin
                acc_next = prod_reg >>> 32;
                state_next = S_DM2;
            end
            S_DM2: begin
                acc_next = acc_reg + prod_reg;
                state_next = S_DMCHK;
            end
            S_DMCHK: begin
                d32_next = neg_reg ? -dm[31:0] : dm[31:0];
                h32_next = neg_reg ? -dm[32:1] : dm[32:1];
                big_next = (dm[55:16] != '0);
                if (dm != '0) begin
                    arc_next = 1'b1;
                    cor_sel_next = 1'b0;
                    state_next = S_CST;
                end else begin
                    c_next  = ONE_Q30;
                    s2_next = '0;
                    state_next = S_L0;
                end
            end
            S_CST: begin
                flip_next = cor_tmp[31];
                cz_next = op_t'(signed'(cor_tmp[31] ? (cor_ang ^ 32'h80000000) : cor_ang));
                cx_next = CORDIC_X0;
                cy_next = '0;
                cnt_next = '0;
                state_next = S_COR;
            end
            S_COR: begin
                if (cnt_reg == 7'(TRIG_ITERATIONS)) begin
                    if (!cor_sel_reg) begin
                        s2_next = s2_new;
                        if (big_reg) begin
                            quo_next = {s2_abs[31:0], 32'b0};
                            den_next = qm_reg;
                            rem_next = '0;
                            cnt_next = '0;
                            div_sel_next = 1'b1;
                            state_next = S_DIV;
                        end else begin
                            c_next = ONE_Q30;
                            state_next = S_L0;
                        end
                    end else begin
                        sn_next = cor_sf;
                        cs_next = cor_cf;
                        state_next = S_G0;
                    end
                end else begin
                    if (!cz_reg[OPW-1]) begin
                        cx_next = cx_reg - cor_ys;
                        cy_next = cy_reg + cor_xs;
                        cz_next = cz_reg - cor_at;
                    end else begin
                        cx_next = cx_reg + cor_ys;
                        cy_next = cy_reg - cor_xs;
                        cz_next = cz_reg + cor_at;
                    end
                    cnt_next = cnt_reg + 7'd1;
                end
            end
            S_L0: state_next = S_L1;
            S_L1: begin acc_next = prod_reg;           state_next = S_L2; end
            S_L2: begin acc_next = acc_reg + prod_reg; state_next = S_L3; end
            S_L3: begin lx_next = acc_reg[OPW+29:30];  state_next = S_L4; end
            S_L4: begin acc_next = prod_reg;           state_next = S_L5; end
            S_L5: begin acc_next = acc_reg + prod_reg; state_next = S_L6; end
            S_L6: begin
                ly_next = acc_reg[OPW+29:30];
                cor_sel_next = 1'b1;
                state_next = S_CST;
            end
            S_G0: state_next = S_G1;
            S_G1: begin acc_next = prod_reg;           state_next = S_G2; end
            S_G2: begin acc_next = acc_reg - prod_reg; state_next = S_G3; end
            S_G3: begin
                accx_next = sat_r.val;
                clip_next = sat_r.clip;
                state_next = S_G4;
            end
            S_G4: begin acc_next = prod_reg;           state_next = S_G5; end
            S_G5: begin acc_next = acc_reg + prod_reg; state_next = S_G6; end
            S_G6: begin
                accy_next = sat_r.val;
                clip_next = clip_reg | sat_r.clip;
                head_next = head_reg + d32_reg;
                state_next = S_OUT;
            end
            S_OUT: begin
                // hold until the previous result beat is gone
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    ox_next = accx_reg;
                    oy_next = accy_reg;
                    oh_next = hprod[HSH+HDEG_W-1:HSH];
                    oarc_next = arc_reg;
                    osat_next = clip_reg;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            ro_reg      <= RIGHT_OFS_RST;
            lo_reg      <= LEFT_OFS_RST;
            bo_reg      <= BACK_OFS_RST;
            accx_reg    <= '0;
            accy_reg    <= '0;
            head_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            ro_reg      <= ro_next;
            lo_reg      <= lo_next;
            bo_reg      <= bo_next;
            accx_reg    <= accx_next;
            accy_reg    <= accy_next;
            head_reg    <= head_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        rt_reg <= rt_next; bt_reg <= bt_next;
        neg_reg <= neg_next; big_reg <= big_next; arc_reg <= arc_next; clip_reg <= clip_next;
        d32_reg <= d32_next; h32_reg <= h32_next;
        qm_reg <= qm_next; quo_reg <= quo_next; den_reg <= den_next; rem_reg <= rem_next;
        cnt_reg <= cnt_next; div_sel_reg <= div_sel_next; cor_sel_reg <= cor_sel_next;
        flip_reg <= flip_next;
        cx_reg <= cx_next; cy_reg <= cy_next; cz_reg <= cz_next;
        s2_reg <= s2_next; c_reg <= c_next; lx_reg <= lx_next; ly_reg <= ly_next;
        sn_reg <= sn_next; cs_reg <= cs_next;
        prod_reg <= prod;
        acc_reg <= acc_next;
        ox_reg <= ox_next; oy_reg <= oy_next; oh_reg <= oh_next;
        oarc_reg <= oarc_next; osat_reg <= osat_next;
    end

    assign m_valid           = m_valid_reg;
    assign m_pose_x          = ox_reg;
    assign m_pose_y          = oy_reg;
    assign m_heading_degrees = oh_reg;
    assign m_arc_used        = oarc_reg;
    assign m_saturated       = osat_reg;

endmodule

### sim/three_wheel_pose_checker.sv
`timescale 1ns / 100ps

module three_wheel_pose_checker
    import twpi_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_valid,
    input  logic                     cfg_ready,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [CFG_DAT_W-1:0]     cfg_data,
    input  logic                     s_valid,
    input  logic                     s_ready,
    input  logic [MODE_W-1:0]        s_mode,
    input  logic [TRAV_W-1:0]        s_left_travel,
    input  logic [TRAV_W-1:0]        s_right_travel,
    input  logic [TRAV_W-1:0]        s_back_travel,
    input  logic                     m_valid,
    input  logic                     m_ready,
    input  logic [POSE_W-1:0]        m_pose_x,
    input  logic [POSE_W-1:0]        m_pose_y,
    input  logic [HDEG_W-1:0]        m_heading_degrees,
    input  logic                     m_arc_used,
    input  logic                     m_saturated,
    output int                       fail_count,
    output int                       backlog
);

    typedef struct {
        logic [POSE_W-1:0] x;
        logic [POSE_W-1:0] y;
        logic [HDEG_W-1:0] hdeg;
        logic              arc;
        logic              sat;
    } pose_t;

    localparam int STEPS = 24;
    localparam logic [31:0] ATAN_LUT [0:STEPS-1] = '{
        32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
        32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2E, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C, 32'h000028BE, 32'h0000145F,
        32'h00000A2F, 32'h00000517, 32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051
    };
    localparam logic [63:0] TURNS_PER_RAD = 64'd683565276;
    localparam longint      GAIN_START    = 652032875;

    pose_t                    pose_q[$];
    logic [OFS_W-1:0]         right_ofs, left_ofs;
    logic [BOFS_W-1:0]        back_ofs;
    logic signed [POSE_W-1:0] pos_x, pos_y;
    logic [31:0]              head;

    function automatic void turn_sincos(input logic [31:0] ang, output longint sn,
                                        output longint cs);
        logic [31:0] a, probe;
        logic        flip;
        longint      x, y, z, t;
        a = ang;
        probe = a + 32'h40000000;
        flip = probe[31];
        if (flip) begin
            a = a - 32'h80000000;
        end
        z = longint'($signed(a));
        x = GAIN_START;
        y = 0;
        for (int i = 0; i < STEPS; i++) begin
            if (z >= 0) begin
                t = x - (y >>> i);
                y = y + (x >>> i);
                z = z - longint'(ATAN_LUT[i]);
            end else begin
                t = x + (y >>> i);
                y = y - (x >>> i);
                z = z + longint'(ATAN_LUT[i]);
            end
            x = t;
        end
        if (flip) begin
            x = -x;
            y = -y;
        end
        sn = y;
        cs = x;
    endfunction

    function automatic pose_t integrate(input logic [MODE_W-1:0] mode, input logic [23:0] l,
                                        input logic [23:0] r, input logic [23:0] b);
        pose_t       p;
        longint      lt, rt, bt, bov, diff, c, s2, sn, cs, lx, ly, gx, gy, sx, sy, cm;
        logic [63:0] sum, qm, dm, sm, hd;
        logic [31:0] d32, h32;
        logic        neg;
        p.arc = 1'b0;
        p.sat = 1'b0;
        if (mode == MODE_RST_X || mode == MODE_RST_ALL) pos_x = '0;
        if (mode == MODE_RST_Y || mode == MODE_RST_ALL) pos_y = '0;
        if (mode == MODE_RST_HEAD || mode == MODE_RST_ALL) head = '0;
        if (mode == MODE_UPDATE) begin
            lt = longint'($signed(l));
            rt = longint'($signed(r));
            bt = longint'($signed(b));
            bov = longint'($signed(back_ofs));
            sum = 64'(right_ofs) + 64'(left_ofs);
            diff = lt - rt;
            neg = diff < 0;
            qm = '0;
            if (sum != 0) qm = (64'(neg ? -diff : diff) << 32) / sum;
            dm = (qm >> 32) * TURNS_PER_RAD + (((qm & 64'hFFFFFFFF) * TURNS_PER_RAD) >> 32);
            d32 = dm[31:0];
            h32 = dm[32:1];
            if (neg) begin
                d32 = -d32;
                h32 = -h32;
            end
            c = longint'(1) << 30;
            s2 = 0;
            if (dm != 0) begin
                p.arc = 1'b1;
                turn_sincos(h32, sn, cs);
                s2 = 2 * sn;
                if (dm >= 64'd65536) begin
                    sm = 64'(s2 < 0 ? -s2 : s2);
                    cm = longint'((sm << 32) / qm);
                    c = ((s2 < 0) != neg) ? -cm : cm;
                end
            end
            lx = (c * bt + s2 * bov) >>> 30;
            ly = (c * rt + s2 * longint'(right_ofs)) >>> 30;
            turn_sincos(head + h32, sn, cs);
            gx = (lx * cs - ly * sn) >>> 30;
            gy = (lx * sn + ly * cs) >>> 30;
            sx = longint'(pos_x) + gx;
            sy = longint'(pos_y) + gy;
            // clip at the signed 32-bit limits
            if (sx > 64'sh7FFFFFFF) begin
                sx = 64'sh7FFFFFFF; p.sat = 1'b1;
            end else if (sx < -64'sh80000000) begin
                sx = -64'sh80000000; p.sat = 1'b1;
            end
            if (sy > 64'sh7FFFFFFF) begin
                sy = 64'sh7FFFFFFF; p.sat = 1'b1;
            end else if (sy < -64'sh80000000) begin
                sy = -64'sh80000000; p.sat = 1'b1;
            end
            pos_x = sx[31:0];
            pos_y = sy[31:0];
            head = head + d32;
        end
        hd = (64'(head) * 64'd360) >> 16;
        p.x = pos_x;
        p.y = pos_y;
        p.hdeg = hd[HDEG_W-1:0];
        return p;
    endfunction

    always @(posedge aclk) begin
        pose_t want;
        if (!aresetn) begin
            right_ofs = RIGHT_OFS_RST;
            left_ofs = LEFT_OFS_RST;
            back_ofs = BACK_OFS_RST;
            pos_x = '0;
            pos_y = '0;
            head = '0;
            pose_q.delete();
            fail_count = 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_RIGHT_OFS: right_ofs = cfg_data[OFS_W-1:0];
                    REG_LEFT_OFS:  left_ofs = cfg_data[OFS_W-1:0];
                    REG_BACK_OFS:  back_ofs = cfg_data[BOFS_W-1:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready)
                pose_q.push_back(integrate(s_mode, s_left_travel, s_right_travel,
                                           s_back_travel));
            if (m_valid && m_ready) begin
                if (pose_q.size() == 0) begin
                    $error("result beat with nothing expected");
                    fail_count++;
                end else begin
                    want = pose_q.pop_front();
                    if (m_pose_x !== want.x) begin
                        $error("pose_x expected %0d got %0d", $signed(want.x),
                               $signed(m_pose_x));
                        fail_count++;
                    end
                    if (m_pose_y !== want.y) begin
                        $error("pose_y expected %0d got %0d", $signed(want.y),
                               $signed(m_pose_y));
                        fail_count++;
                    end
                    if (m_heading_degrees !== want.hdeg) begin
                        $error("heading_degrees expected %0d got %0d", want.hdeg,
                               m_heading_degrees);
                        fail_count++;
                    end
                    if (m_arc_used !== want.arc) begin
                        $error("arc_used expected %0d got %0d", want.arc, m_arc_used);
                        fail_count++;
                    end
                    if (m_saturated !== want.sat) begin
                        $error("saturated expected %0d got %0d", want.sat, m_saturated);
                        fail_count++;
                    end
                end
            end
        end
        backlog = pose_q.size();
    end

endmodule

### sim/three_wheel_pose_integrator_tb.sv
`timescale 1ns / 100ps

module three_wheel_pose_integrator_tb;
    import twpi_pkg::*;

    localparam int SETTLE = 300;
    localparam int STALL_LIMIT = 20000;
    localparam logic [MODE_W-1:0] MODE_UNKNOWN = 3'd5;

    logic                     aclk, aresetn;
    logic                     cfg_valid, cfg_ready;
    logic [CFG_IDX_W-1:0]     cfg_index;
    logic [CFG_DAT_W-1:0]     cfg_data;
    logic                     s_valid, s_ready;
    logic [MODE_W-1:0]        s_mode;
    logic [TRAV_W-1:0]        s_left_travel, s_right_travel, s_back_travel;
    logic                     m_valid, m_ready;
    logic [POSE_W-1:0]        m_pose_x, m_pose_y;
    logic [HDEG_W-1:0]        m_heading_degrees;
    logic                     m_arc_used, m_saturated;
    int                       fail_count, backlog;
    int                       quiet_cycles;
    logic                     no_gaps;

    three_wheel_pose_integrator uut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_mode(s_mode),
        .s_left_travel(s_left_travel), .s_right_travel(s_right_travel),
        .s_back_travel(s_back_travel),
        .m_valid(m_valid), .m_ready(m_ready), .m_pose_x(m_pose_x), .m_pose_y(m_pose_y),
        .m_heading_degrees(m_heading_degrees), .m_arc_used(m_arc_used),
        .m_saturated(m_saturated)
    );

    three_wheel_pose_checker chk (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_mode(s_mode),
        .s_left_travel(s_left_travel), .s_right_travel(s_right_travel),
        .s_back_travel(s_back_travel),
        .m_valid(m_valid), .m_ready(m_ready), .m_pose_x(m_pose_x), .m_pose_y(m_pose_y),
        .m_heading_degrees(m_heading_degrees), .m_arc_used(m_arc_used),
        .m_saturated(m_saturated),
        .fail_count(fail_count), .backlog(backlog)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // result side: random stall before each beat
    always @(posedge aclk) begin
        int hold;
        logic rdy;
        if (!aresetn) begin
            hold = 0;
            m_ready <= 1'b0;
        end else begin
            rdy = 1'b1;
            if (m_valid && m_ready) begin
                hold = no_gaps ? 0 : $urandom_range(0, 13);
            end
            if (hold > 0) begin
                hold--;
                rdy = 1'b0;
            end
            m_ready <= rdy;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) ||
            (cfg_valid && cfg_ready) || backlog == 0 && !s_valid && !cfg_valid) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    task automatic send(input logic [MODE_W-1:0] mode, input logic [23:0] l,
                        input logic [23:0] r, input logic [23:0] b);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 13);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_mode <= mode;
        s_left_travel <= l;
        s_right_travel <= r;
        s_back_travel <= b;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic drain;
        s_valid <= 1'b0;
        @(posedge aclk);
        while (backlog != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_geometry(input logic [25:0] ro, input logic [25:0] lo,
                                input logic [26:0] bo);
        drain();
        write_reg(REG_RIGHT_OFS, 27'(ro));
        write_reg(REG_LEFT_OFS, 27'(lo));
        write_reg(REG_BACK_OFS, bo);
    endtask

    function automatic logic [23:0] travel(input int spread);
        int pick;
        pick = $urandom_range(0, 9);
        if (pick == 0) return 24'h7FFFFF;
        if (pick == 1) return 24'h800000;
        if (spread == 0 || pick < 5) return 24'($urandom);
        return 24'($signed($urandom_range(0, 2 * spread)) - spread);
    endfunction

    task automatic random_items(input int count, input bit drive);
        logic [23:0] l, r, dl;
        int pick;
        for (int n = 0; n < count; n++) begin
            if (n % 40 == 0) no_gaps = ($urandom_range(0, 3) == 0);
            pick = $urandom_range(0, 99);
            if (drive) begin
                // long straight runs push the pose into the clip limits
                l = 24'h600000 + 24'($urandom_range(0, 24'h1FFFFF));
                if (pick < 2) send(MODE_RST_ALL, travel(0), travel(0), travel(0));
                else if (pick < 50) send(MODE_UPDATE, l, l, travel(0));
                else send(MODE_UPDATE, -l, -l, -travel(65536));
            end else if (pick < 4) begin
                send(MODE_W'($urandom_range(1, 4)), travel(0), travel(0), travel(0));
            end else if (pick < 7) begin
                send(MODE_W'($urandom_range(5, 7)), travel(0), travel(0), travel(0));
            end else if (pick < 40) begin
                send(MODE_UPDATE, travel(0), travel(0), travel(0));
            end else if (pick < 70) begin
                send(MODE_UPDATE, travel(65536), travel(65536), travel(65536));
            end else begin
                r = travel(0);
                dl = 24'($signed($urandom_range(0, 400)) - 200);
                l = r + dl;
                send(MODE_UPDATE, l, r, travel(0));
            end
        end
        no_gaps = 1'b0;
    endtask

    initial begin
        aresetn <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data <= '0;
        s_valid <= 1'b0;
        s_mode <= MODE_UPDATE;
        s_left_travel <= '0;
        s_right_travel <= '0;
        s_back_travel <= '0;
        no_gaps = 1'b0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: straight, tiny and huge turns, every mode
        send(MODE_UPDATE, 24'd0, 24'd0, 24'd0);
        send(MODE_UPDATE, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF);
        send(MODE_UPDATE, 24'h800000, 24'h800000, 24'h800000);
        send(MODE_UPDATE, 24'h7FFFFF, 24'h800000, 24'h7FFFFF);
        send(MODE_UPDATE, 24'h800000, 24'h7FFFFF, 24'h800000);
        send(MODE_UPDATE, 24'd1, 24'd0, 24'd100);
        send(MODE_UPDATE, 24'd0, 24'd1, 24'hFFFF00);
        send(MODE_UPDATE, 24'd120, 24'd0, 24'd0);
        send(MODE_UPDATE, 24'd65536, 24'd0, 24'd65536);
        send(MODE_UPDATE, 24'd0, 24'd65536, 24'hFF0000);
        send(MODE_RST_X, 24'h7FFFFF, 24'h800000, 24'd5);
        send(MODE_UPDATE, 24'd300000, 24'd100000, 24'd7000);
        send(MODE_RST_Y, 24'd0, 24'd0, 24'd0);
        send(MODE_UPDATE, 24'd300000, 24'd100000, 24'd7000);
        send(MODE_RST_HEAD, 24'd0, 24'd0, 24'd0);
        send(MODE_UNKNOWN, 24'd0, 24'd0, 24'd0);
        send(MODE_RST_ALL, 24'h123456, 24'h654321, 24'h0F0F0F);
        set_geometry(26'd1, 26'd1, 27'h4000000);
        send(MODE_UPDATE, 24'h7FFFFF, 24'h800000, 24'h7FFFFF);
        send(MODE_UPDATE, 24'd1, 24'd0, 24'h800000);
        send(MODE_UPDATE, 24'h800000, 24'h7FFFFF, 24'd3);
        set_geometry(26'h3FFFFFF, 26'h3FFFFFF, 27'h3FFFFFF);
        send(MODE_UPDATE, 24'h7FFFFF, 24'h800000, 24'h800000);
        send(MODE_UPDATE, 24'd5, 24'd0, 24'h7FFFFF);

        random_items(250, 1'b0);
        set_geometry(RIGHT_OFS_RST, LEFT_OFS_RST, BACK_OFS_RST);
        random_items(300, 1'b1);
        set_geometry(26'($urandom_range(1, 26'h3FFFFFF)), 26'($urandom_range(1, 2000000)),
                     27'($urandom));
        random_items(250, 1'b0);
        set_geometry(26'd1, 26'd1, 27'h4000000);
        random_items(150, 1'b0);
        set_geometry(26'($urandom_range(65536, 1000000)), 26'($urandom_range(65536, 1000000)),
                     27'($signed($urandom_range(0, 2000000)) - 1000000));
        random_items(280, 1'b0);

        drain();
        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
